FILE: rtl/pep_pkg.sv
// Shared widths, defaults and register indexes of the polynomial evaluator.
`default_nettype none

package pep_pkg;

   localparam int DATA_W  = 32;
   localparam int PROD_W  = 64;
   localparam int ACC_W   = 64;
   localparam int INDEX_W = 3;

   localparam int MAX_TERMS_DEF = 7;
   localparam int FRAC_BITS_DEF = 16;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic signed [PROD_W-1:0] prod_type;

   // Configuration register indexes.
   localparam logic [INDEX_W-1:0] CSR_TERM_COUNT = 3'd0;
   localparam logic [INDEX_W-1:0] CSR_COEF_BASE  = 3'd1;

endpackage

`default_nettype wire

FILE: rtl/polynomial_eval_with_powers.sv
// Top level of the fixed-point polynomial evaluator with design-matrix powers.
//
// An item (req_arg_value x, req_prior_value) is taken at a clock edge where start
// is high and busy is low. The block then emits one result per term k, in
// ascending order: rsp_power_index k, rsp_power_value x^k, and on the last
// result of the run (rsp_last_of_run high) rsp_model_value, which is the prior
// value plus the polynomial sum; rsp_model_value is zero on the other results.
// Each result is shown for one cycle with rsp_valid high; the receiver cannot
// stall, so results are never held back.
// One signed 32x32 multiplier does all the work: each term needs one multiply
// for the next power and one for the coefficient product, so the block passes
// through S_ISSUE and S_ACC for the first term and S_POW and S_ACC for each
// further one; results come one at a time. Busy stays high until the last
// result is shown; a new item may be started in the cycle in which it is shown.
// Coefficients and the term count are to be written through the csr_ port only
// while the block is idle; the block itself does not enforce this. Reset sets the
// term count to one, clears all coefficients and drops busy and rsp_valid.
`default_nettype none

module polynomial_eval_with_powers #(
   parameter int MAX_TERMS = pep_pkg::MAX_TERMS_DEF,
   parameter int FRAC_BITS = pep_pkg::FRAC_BITS_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 start,
   output logic                                busy,
   input  wire signed [pep_pkg::DATA_W-1:0]    req_arg_value,
   input  wire signed [pep_pkg::DATA_W-1:0]    req_prior_value,
   output logic                                rsp_valid,
   output logic [pep_pkg::INDEX_W-1:0]         rsp_power_index,
   output pep_pkg::data_type                   rsp_power_value,
   output pep_pkg::data_type                   rsp_model_value,
   output logic                                rsp_last_of_run,
   input  wire                                 csr_we,
   input  wire  [pep_pkg::INDEX_W-1:0]         csr_index,
   input  wire  [pep_pkg::DATA_W-1:0]          csr_wdata
);

   localparam int COEF_IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int IW      = pep_pkg::INDEX_W;
   localparam int DW      = pep_pkg::DATA_W;
   localparam int AW      = pep_pkg::ACC_W;
   localparam pep_pkg::data_type ONE = DW'(1) << FRAC_BITS;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ISSUE,
      S_ACC,
      S_POW
   } state_type;

   typedef logic signed [AW-1:0] acc_type;

   function automatic pep_pkg::data_type sat32(input pep_pkg::prod_type v);
      pep_pkg::data_type r;
      if (v[AW-1:DW-1] == {(AW-DW+1){1'b0}} || v[AW-1:DW-1] == {(AW-DW+1){1'b1}}) begin
         r = v[DW-1:0];
      end else begin
         r = v[AW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      end
      return r;
   endfunction

   function automatic acc_type add_sat(input acc_type a, input pep_pkg::prod_type b);
      logic [AW:0] s;
      acc_type     r;
      s = {a[AW-1], a} + {b[AW-1], b};
      if (s[AW] != s[AW-1]) begin
         r = s[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
      end else begin
         r = s[AW-1:0];
      end
      return r;
   endfunction

   state_type           state_ff, state_in;
   logic [IW-1:0]       k_ff, k_in;
   logic [IW-1:0]       nlast_ff, nlast_in;
   pep_pkg::data_type   x_ff, x_in;
   pep_pkg::data_type   pw_ff, pw_in;
   acc_type             acc_ff, acc_in;
   logic [IW-1:0]       term_count_ff, term_count_in;
   pep_pkg::data_type   coef_ff [MAX_TERMS];
   pep_pkg::data_type   coef_in [MAX_TERMS];

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [IW-1:0]       rsp_index_ff, rsp_index_in;
   pep_pkg::data_type   rsp_power_ff, rsp_power_in;
   pep_pkg::data_type   rsp_model_ff, rsp_model_in;

   pep_pkg::data_type   mul_a, mul_b;
   pep_pkg::prod_type   prod;
   pep_pkg::data_type   pw_sat;
   acc_type             acc_next;
   logic [IW-1:0]       coef_widx;
   logic [COEF_IW-1:0]  kidx;

   pep_mul #(
      .FRAC_BITS(FRAC_BITS)
   ) u_mul (
      .clock(clock),
      .op_a (mul_a),
      .op_b (mul_b),
      .prod (prod)
   );

   assign pw_sat    = sat32(prod);
   assign acc_next  = add_sat(acc_ff, prod);
   assign coef_widx = csr_index - pep_pkg::CSR_COEF_BASE;
   assign kidx      = k_ff[COEF_IW-1:0];

   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      nlast_in      = nlast_ff;
      x_in          = x_ff;
      pw_in         = pw_ff;
      acc_in        = acc_ff;
      term_count_in = term_count_ff;
      coef_in       = coef_ff;
      rsp_valid_in  = 1'b0;
      rsp_last_in   = 1'b0;
      rsp_index_in  = k_ff;
      rsp_power_in  = pw_ff;
      rsp_model_in  = '0;
      mul_a         = coef_ff[kidx];
      mul_b         = pw_ff;

      if (csr_we) begin
         if (csr_index == pep_pkg::CSR_TERM_COUNT) begin
            term_count_in = csr_wdata[IW-1:0];
         end else if (coef_widx < IW'(MAX_TERMS)) begin
            coef_in[coef_widx[COEF_IW-1:0]] = csr_wdata;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               x_in   = req_arg_value;
               acc_in = AW'(req_prior_value);
               pw_in  = ONE;
               k_in   = '0;
               // A term count of zero runs the constant term alone.
               if (term_count_ff == '0) begin
                  nlast_in = '0;
               end else if (term_count_ff > IW'(MAX_TERMS)) begin
                  nlast_in = IW'(MAX_TERMS - 1);
               end else begin
                  nlast_in = term_count_ff - IW'(1);
               end
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            acc_in       = acc_next;
            rsp_valid_in = 1'b1;
            if (k_ff == nlast_ff) begin
               rsp_last_in  = 1'b1;
               rsp_model_in = sat32(acc_next);
               state_in     = S_IDLE;
            end else begin
               // The multiplier is free here, so the next power starts now.
               mul_a    = pw_ff;
               mul_b    = x_ff;
               k_in     = k_ff + IW'(1);
               state_in = S_POW;
            end
         end
         S_POW: begin
            pw_in    = pw_sat;
            mul_b    = pw_sat;
            state_in = S_ACC;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         term_count_ff <= IW'(1);
         for (int i = 0; i < MAX_TERMS; i++) begin
            coef_ff[i] <= '0;
         end
         rsp_valid_ff  <= 1'b0;
         rsp_last_ff   <= 1'b0;
         k_ff          <= '0;
         nlast_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         term_count_ff <= term_count_in;
         coef_ff       <= coef_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_last_ff   <= rsp_last_in;
         k_ff          <= k_in;
         nlast_ff      <= nlast_in;
      end
      x_ff         <= x_in;
      pw_ff        <= pw_in;
      acc_ff       <= acc_in;
      rsp_index_ff <= rsp_index_in;
      rsp_power_ff <= rsp_power_in;
      rsp_model_ff <= rsp_model_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_power_index = rsp_index_ff;
   assign rsp_power_value = rsp_power_ff;
   assign rsp_model_value = rsp_model_ff;

   // The model value is only carried on the final result of a run.
   a_model_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_of_run) |-> (rsp_model_value == '0))
      else $error("model value nonzero on an intermediate result");

   // An intermediate result always means more work for this item.
   a_more_after: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_of_run) |-> busy)
      else $error("intermediate result while idle");

   // The final result leaves the block idle.
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_of_run) |-> !busy)
      else $error("block still busy after final result");

   // The last result carries the clamped final index of the run.
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_of_run) |-> (rsp_power_index == nlast_ff))
      else $error("final result at wrong power index");

   // An accepted item makes the block busy on the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not start a run");

endmodule

`default_nettype wire

FILE: rtl/pep_mul.sv
// Shared signed multiplier with a registered, floor-scaled product.
`default_nettype none

module pep_mul #(
   parameter int FRAC_BITS = pep_pkg::FRAC_BITS_DEF
) (
   input  wire                              clock,
   input  wire signed [pep_pkg::DATA_W-1:0] op_a,
   input  wire signed [pep_pkg::DATA_W-1:0] op_b,
   output pep_pkg::prod_type                prod
);

   pep_pkg::prod_type full;
   pep_pkg::prod_type prod_ff;

   // An arithmetic right shift of the full product rounds toward minus infinity.
   assign full = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= full >>> FRAC_BITS;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire
